// File: hw/rtl/lsc_pkg.sv
// Shared types and constants for the light selection cache.
// No dependencies.
package lsc_pkg;

	localparam int ID_W     = 16;
	localparam int POS_W    = 24;
	localparam int RADIUS_W = 23;
	localparam int MAG_W    = 24;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int DIST_W   = SQ_W + 2;
	localparam int STEP_W   = 3;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	// distance sequencer: 4 operands through abs, square and accumulate
	localparam logic [STEP_W-1:0] DIST_STEP_Y     = 3'd1;
	localparam logic [STEP_W-1:0] DIST_STEP_Z     = 3'd2;
	localparam logic [STEP_W-1:0] DIST_STEP_REACH = 3'd3;
	localparam logic [STEP_W-1:0] DIST_LAST       = 3'd5;

	typedef enum logic [1:0] {
		OP_REFRESH = 2'd0,
		OP_RESET   = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam logic [1:0] LT_POSITIONAL  = 2'd0;
	localparam logic [1:0] LT_DIRECTIONAL = 2'd1;
	localparam logic [1:0] LT_AMBIENT     = 2'd2;

	localparam logic [2:0] REG_SPHERE_X      = 3'd0;
	localparam logic [2:0] REG_SPHERE_Y      = 3'd1;
	localparam logic [2:0] REG_SPHERE_Z      = 3'd2;
	localparam logic [2:0] REG_SPHERE_RADIUS = 3'd3;
	localparam logic [2:0] REG_EXCLUDE       = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIST,
		ST_UPDATE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_INSERT,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_READ_RD,
		ST_READ_OUT,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/light_selection_cache_core.sv
// Light selection cache: id table, count and ambient slot for one render target.
// Depends on lsc_pkg.
//
// One transaction is taken when start is high and busy is low; busy stays high
// until the result, which shows for exactly one cycle with done high and cannot
// be held off. A refresh of an ambient light, or of an eligible light while the
// table is full, skips the table. Any other refresh walks the table one entry at
// a time through its single read port, ending when the id is found in place,
// when it is absent, or after an insert or a swap-last removal. A light that is
// neither directional nor ambient and passes the basic checks first goes through
// the one shared squaring multiplier for the three distance terms and the reach.
module light_selection_cache_core
	import lsc_pkg::*;
#(
	parameter int LIGHT_CAPACITY = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready,
	// command
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [ID_W-1:0]            light_id,
	input  logic [1:0]                 light_type,
	input  logic                       enabled,
	input  logic                       hierarchy_active,
	input  logic                       casts_shadow_volume,
	input  logic signed [POS_W-1:0]    pos_x,
	input  logic signed [POS_W-1:0]    pos_y,
	input  logic signed [POS_W-1:0]    pos_z,
	input  logic [RADIUS_W-1:0]        light_range,
	input  logic [7:0]                 slot_index,
	// result
	output logic                       done,
	output logic                       eligible,
	output logic [7:0]                 selected_count,
	output logic                       ambient_valid,
	output logic [ID_W-1:0]            ambient_id,
	output logic                       slot_valid,
	output logic [ID_W-1:0]            slot_light_id
);

	localparam int AW = (LIGHT_CAPACITY > 1) ? $clog2(LIGHT_CAPACITY) : 1;
	localparam int CW = $clog2(LIGHT_CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(LIGHT_CAPACITY);

	state_t state_q, state_d;

	// configuration
	logic signed [POS_W-1:0] sphere_x_q, sphere_y_q, sphere_z_q;
	logic [RADIUS_W-1:0]     sphere_radius_q;
	logic                    exclude_q;
	logic                    cfg_we;

	// selection state
	logic [CW-1:0]   count_q;
	logic            amb_valid_q;
	logic [ID_W-1:0] amb_id_q;

	// captured transaction
	op_t                     op_q;
	logic [ID_W-1:0]         id_q;
	logic [1:0]              type_q;
	logic                    basic_ok_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [RADIUS_W-1:0]     range_q;
	logic [7:0]              slot_index_q;

	// working registers
	logic                    elig_q;
	logic                    slot_valid_q;
	logic [ID_W-1:0]         slot_id_q;
	logic [STEP_W-1:0]       step_q;
	logic [MAG_W-1:0]        mag_q;
	logic [SQ_W-1:0]         prod_q;
	logic [DIST_W-1:0]       dist_q;
	logic [CW-1:0]           idx_q;

	// table memory
	logic [ID_W-1:0] slot_mem [LIGHT_CAPACITY];
	logic [ID_W-1:0] rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [ID_W-1:0] mem_wdata;

	logic                    is_ambient;
	logic                    is_fixed_pass;
	logic                    id_match;
	logic                    read_in_range;
	logic [CW-1:0]           count_m1;
	logic signed [POS_W-1:0] op_pos, op_ctr;
	logic signed [POS_W:0]   diff;
	logic [MAG_W-1:0]        mag_d;
	logic [SQ_W-1:0]         sq;

	assign is_ambient    = (type_q == LT_AMBIENT);
	assign is_fixed_pass = (type_q == LT_DIRECTIONAL) || (type_q == LT_AMBIENT);
	assign id_match      = (rdata_q == id_q);
	assign read_in_range = (slot_index_q < 8'(count_q));
	assign count_m1      = count_q - CW'(1);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_x_q      <= '0;
			sphere_y_q      <= '0;
			sphere_z_q      <= '0;
			sphere_radius_q <= '0;
			exclude_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[4:2])
				REG_SPHERE_X:      sphere_x_q      <= pwdata[POS_W-1:0];
				REG_SPHERE_Y:      sphere_y_q      <= pwdata[POS_W-1:0];
				REG_SPHERE_Z:      sphere_z_q      <= pwdata[POS_W-1:0];
				REG_SPHERE_RADIUS: sphere_radius_q <= pwdata[RADIUS_W-1:0];
				REG_EXCLUDE:       exclude_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_SPHERE_X:      prdata = APB_DW'(unsigned'(sphere_x_q));
			REG_SPHERE_Y:      prdata = APB_DW'(unsigned'(sphere_y_q));
			REG_SPHERE_Z:      prdata = APB_DW'(unsigned'(sphere_z_q));
			REG_SPHERE_RADIUS: prdata = APB_DW'(sphere_radius_q);
			REG_EXCLUDE:       prdata = APB_DW'(exclude_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_REFRESH: state_d = ST_CHECK;
						OP_READ:    state_d = ST_READ_RD;
						OP_RESET,
						OP_NONE:    state_d = ST_FINISH;
					endcase
				end
			end
			ST_CHECK: begin
				if (!basic_ok_q || is_fixed_pass) begin
					state_d = ST_UPDATE;
				end else begin
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				if (step_q == DIST_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				priority if (is_ambient) begin
					state_d = ST_FINISH;
				end else if (elig_q && (count_q >= CAP)) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (idx_q == count_q) begin
					state_d = elig_q ? ST_INSERT : ST_FINISH;
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				priority if (!id_match) begin
					state_d = ST_SCAN_RD;
				end else if (!elig_q && (idx_q != count_m1)) begin
					state_d = ST_MOVE_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_INSERT:   state_d = ST_FINISH;
			ST_MOVE_RD:  state_d = ST_MOVE_WR;
			ST_MOVE_WR:  state_d = ST_FINISH;
			ST_READ_RD:  state_d = read_in_range ? ST_READ_OUT : ST_FINISH;
			ST_READ_OUT: state_d = ST_FINISH;
			ST_FINISH:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_FINISH);

	// ---------------- shared abs / square unit ----------------
	always_comb begin
		unique case (step_q)
			3'd0:        begin op_pos = pos_x_q; op_ctr = sphere_x_q; end
			DIST_STEP_Y: begin op_pos = pos_y_q; op_ctr = sphere_y_q; end
			default:     begin op_pos = pos_z_q; op_ctr = sphere_z_q; end
		endcase
		diff = (POS_W + 1)'(op_pos) - (POS_W + 1)'(op_ctr);
		if (step_q == DIST_STEP_REACH) begin
			mag_d = MAG_W'(range_q) + MAG_W'(sphere_radius_q);
		end else if (diff < 0) begin
			mag_d = MAG_W'(-diff);
		end else begin
			mag_d = MAG_W'(diff);
		end
	end

	assign sq = SQ_W'(mag_q) * SQ_W'(mag_q);

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q         <= op_t'(operation);
					id_q         <= light_id;
					type_q       <= light_type;
					basic_ok_q   <= enabled && hierarchy_active &&
						!(exclude_q && casts_shadow_volume);
					pos_x_q      <= pos_x;
					pos_y_q      <= pos_y;
					pos_z_q      <= pos_z;
					range_q      <= light_range;
					slot_index_q <= slot_index;
					elig_q       <= 1'b0;
					slot_valid_q <= 1'b0;
					slot_id_q    <= '0;
				end
			end
			ST_CHECK: begin
				elig_q <= basic_ok_q;
				step_q <= '0;
			end
			ST_DIST: begin
				step_q <= step_q + STEP_W'(1);
				mag_q  <= mag_d;
				prod_q <= sq;
				if (step_q == 3'd2) begin
					dist_q <= DIST_W'(prod_q);
				end else if (step_q == 3'd3 || step_q == 3'd4) begin
					dist_q <= dist_q + DIST_W'(prod_q);
				end
				if (step_q == DIST_LAST) begin
					elig_q <= (dist_q <= DIST_W'(prod_q));
				end
			end
			ST_UPDATE: idx_q <= '0;
			ST_SCAN_CMP: begin
				if (!id_match) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_READ_OUT: begin
				slot_valid_q <= 1'b1;
				slot_id_q    <= rdata_q;
			end
			default: ;
		endcase
	end

	// ---------------- selection state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			amb_valid_q <= 1'b0;
			amb_id_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && (op_t'(operation) == OP_RESET)) begin
						count_q     <= '0;
						amb_valid_q <= 1'b0;
						amb_id_q    <= '0;
					end
				end
				ST_UPDATE: begin
					if (is_ambient) begin
						if (elig_q && !amb_valid_q) begin
							amb_valid_q <= 1'b1;
							amb_id_q    <= id_q;
						end else if (!elig_q && amb_valid_q && (amb_id_q == id_q)) begin
							amb_valid_q <= 1'b0;
							amb_id_q    <= '0;
						end
					end
				end
				ST_SCAN_CMP: begin
					if (id_match && !elig_q) begin
						count_q <= count_m1;
					end
				end
				ST_INSERT: count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	// ---------------- id table ----------------
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rdata_q;
		mem_raddr = idx_q[AW-1:0];
		unique case (state_q)
			ST_INSERT: begin
				mem_we    = 1'b1;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = id_q;
			end
			ST_MOVE_WR: mem_we = 1'b1;
			ST_MOVE_RD: mem_raddr = count_q[AW-1:0];
			ST_READ_RD: mem_raddr = slot_index_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= slot_mem[mem_raddr];
	end

	// ---------------- result ----------------
	assign eligible       = elig_q;
	assign selected_count = 8'(count_q);
	assign ambient_valid  = amb_valid_q;
	assign ambient_id     = amb_id_q;
	assign slot_valid     = slot_valid_q;
	assign slot_light_id  = slot_id_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("selection count above capacity");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_elig_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(done && eligible) |-> (op_q == OP_REFRESH))
		else $error("eligible reported for a non-refresh transaction");

	a_amb_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!amb_valid_q |-> (amb_id_q == '0))
		else $error("ambient id held without a valid ambient light");

endmodule

// File: tb/light_selection_cache_core_tb.sv
// Self-checking testbench for light_selection_cache_core: directed and random commands,
// APB register set-up between phases, results checked against an in-bench predictor.
// Depends on lsc_pkg and light_selection_cache_core.
module light_selection_cache_core_tb;
	import lsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY    = 8;
	localparam int ID_POOL     = 12;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE      = 40;
	localparam logic [1:0] LT_OTHER = 2'd3;

	typedef struct packed {
		op_t         op;
		logic [15:0] id;
		logic [1:0]  ltype;
		logic        en;
		logic        act;
		logic        shd;
		logic [23:0] px;
		logic [23:0] py;
		logic [23:0] pz;
		logic [22:0] rng;
		logic [7:0]  idx;
	} command_t;

	typedef struct packed {
		logic        eligible;
		logic [7:0]  count;
		logic        amb_valid;
		logic [15:0] amb_id;
		logic        slot_valid;
		logic [15:0] slot_id;
	} selection_t;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               start, busy, done;
	logic [1:0]         operation;
	logic [15:0]        light_id;
	logic [1:0]         light_type;
	logic               enabled, hierarchy_active, casts_shadow_volume;
	logic [23:0]        pos_x, pos_y, pos_z;
	logic [22:0]        light_range;
	logic [7:0]         slot_index;
	logic               eligible, ambient_valid, slot_valid;
	logic [7:0]         selected_count;
	logic [15:0]        ambient_id, slot_light_id;

	// predictor state and register shadow
	logic [15:0] held_id [CAPACITY];
	int          held_count = 0;
	logic        amb_on = 1'b0;
	logic [15:0] amb_light = '0;
	logic [23:0] sph_x = '0, sph_y = '0, sph_z = '0;
	logic [22:0] sph_r = '0;
	logic        excl = 1'b0;

	command_t    command_q [$];
	selection_t  selection_q [$];
	command_t    on_bus;
	logic        taken = 1'b0;
	int          idle_pct = 0;
	int          mismatches = 0;
	int          cycles = 0;
	logic [15:0] id_pool [ID_POOL];

	light_selection_cache_core #(.LIGHT_CAPACITY(CAPACITY)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .operation(operation), .light_id(light_id),
		.light_type(light_type), .enabled(enabled), .hierarchy_active(hierarchy_active),
		.casts_shadow_volume(casts_shadow_volume), .pos_x(pos_x), .pos_y(pos_y),
		.pos_z(pos_z), .light_range(light_range), .slot_index(slot_index),
		.done(done), .eligible(eligible), .selected_count(selected_count),
		.ambient_valid(ambient_valid), .ambient_id(ambient_id),
		.slot_valid(slot_valid), .slot_light_id(slot_light_id)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void enqueue(command_t c);
		command_q.insert(command_q.size(), c);
	endfunction

	function automatic logic light_passes(command_t c);
		longint dx, dy, dz, reach;
		if (!c.en || !c.act)
			return 1'b0;
		if (excl && c.shd)
			return 1'b0;
		if (c.ltype == LT_DIRECTIONAL || c.ltype == LT_AMBIENT)
			return 1'b1;
		dx = longint'($signed(c.px)) - longint'($signed(sph_x));
		dy = longint'($signed(c.py)) - longint'($signed(sph_y));
		dz = longint'($signed(c.pz)) - longint'($signed(sph_z));
		reach = longint'(c.rng) + longint'(sph_r);
		return (dx * dx + dy * dy + dz * dz) <= reach * reach;
	endfunction

	function automatic selection_t next_selection(command_t c);
		selection_t r;
		logic       verdict;
		logic       found;
		int         hit;
		r = '0;
		verdict = 1'b0;
		case (c.op)
			OP_REFRESH: begin
				verdict = light_passes(c);
				if (c.ltype == LT_AMBIENT) begin
					if (verdict) begin
						if (!amb_on) begin
							amb_on = 1'b1;
							amb_light = c.id;
						end
					end else if (amb_on && amb_light == c.id) begin
						amb_on = 1'b0;
						amb_light = '0;
					end
				end else if (verdict) begin
					found = 1'b0;
					for (int i = 0; i < held_count; i++)
						if (held_id[i] == c.id)
							found = 1'b1;
					if (!found && held_count < CAPACITY) begin
						held_id[held_count] = c.id;
						held_count++;
					end
				end else begin
					hit = -1;
					for (int i = 0; i < held_count; i++)
						if (hit < 0 && held_id[i] == c.id)
							hit = i;
					if (hit >= 0) begin
						held_count--;
						held_id[hit] = held_id[held_count];
					end
				end
			end
			OP_RESET: begin
				held_count = 0;
				amb_on = 1'b0;
				amb_light = '0;
			end
			OP_READ: begin
				if (int'(c.idx) < held_count) begin
					r.slot_valid = 1'b1;
					r.slot_id = held_id[c.idx];
				end
			end
			default: ;
		endcase
		r.eligible = verdict;
		r.count = 8'(held_count);
		r.amb_valid = amb_on;
		r.amb_id = amb_on ? amb_light : 16'h0000;
		return r;
	endfunction

	function automatic command_t mk(op_t o, logic [15:0] id, logic [1:0] t, logic en,
			logic act, logic shd, logic [23:0] x, logic [23:0] y, logic [23:0] z,
			logic [22:0] rng, logic [7:0] idx);
		command_t c;
		c.op = o;
		c.id = id;
		c.ltype = t;
		c.en = en;
		c.act = act;
		c.shd = shd;
		c.px = x;
		c.py = y;
		c.pz = z;
		c.rng = rng;
		c.idx = idx;
		return c;
	endfunction

	function automatic logic [23:0] near_axis(logic [23:0] centre);
		longint v;
		v = longint'($signed(centre)) + longint'($urandom_range(16384)) - 8192;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	function automatic command_t random_command();
		command_t c;
		int       r;
		r = $urandom_range(99);
		if (r < 72)
			c.op = OP_REFRESH;
		else if (r < 92)
			c.op = OP_READ;
		else if (r < 96)
			c.op = OP_NONE;
		else
			c.op = OP_RESET;
		c.id = ($urandom_range(4) == 0) ? 16'($urandom) : id_pool[$urandom_range(ID_POOL - 1)];
		r = $urandom_range(99);
		if (r < 45)
			c.ltype = LT_POSITIONAL;
		else if (r < 60)
			c.ltype = LT_DIRECTIONAL;
		else if (r < 80)
			c.ltype = LT_AMBIENT;
		else
			c.ltype = LT_OTHER;
		c.en = ($urandom_range(9) != 0);
		c.act = ($urandom_range(9) != 0);
		c.shd = 1'($urandom_range(1));
		if ($urandom_range(3) == 0) begin
			c.px = 24'($urandom);
			c.py = 24'($urandom);
			c.pz = 24'($urandom);
			c.rng = 23'($urandom);
		end else begin
			c.px = near_axis(sph_x);
			c.py = near_axis(sph_y);
			c.pz = near_axis(sph_z);
			c.rng = 23'($urandom_range(16'h2800));
		end
		c.idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(9));
		return c;
	endfunction

	// command driver
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			taken = 1'b0;
			if (command_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				on_bus = command_q.pop_front();
				operation <= on_bus.op;
				light_id <= on_bus.id;
				light_type <= on_bus.ltype;
				enabled <= on_bus.en;
				hierarchy_active <= on_bus.act;
				casts_shadow_volume <= on_bus.shd;
				pos_x <= on_bus.px;
				pos_y <= on_bus.py;
				pos_z <= on_bus.pz;
				light_range <= on_bus.rng;
				slot_index <= on_bus.idx;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor; results are checked before a transaction taken at the same edge
	always @(posedge clk) begin
		selection_t got, want;
		if (arst_n && done) begin
			got = {eligible, selected_count, ambient_valid, ambient_id, slot_valid,
				slot_light_id};
			if (selection_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
			end else begin
				want = selection_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
		if (arst_n && start && !busy) begin
			selection_q.insert(selection_q.size(), next_selection(on_bus));
			taken = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_SPHERE_X:      sph_x = val[23:0];
			REG_SPHERE_Y:      sph_y = val[23:0];
			REG_SPHERE_Z:      sph_z = val[23:0];
			REG_SPHERE_RADIUS: sph_r = val[22:0];
			REG_EXCLUDE:       excl = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(longint x, longint y, longint z, longint r, logic e);
		write_reg(REG_SPHERE_X, 32'(x));
		write_reg(REG_SPHERE_Y, 32'(y));
		write_reg(REG_SPHERE_Z, 32'(z));
		write_reg(REG_SPHERE_RADIUS, 32'(r));
		write_reg(REG_EXCLUDE, {31'd0, e});
	endtask

	task automatic drain();
		while (command_q.size() != 0 || start || selection_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int i = 2; i < ID_POOL; i++)
			id_pool[i] = 16'($urandom);
		for (int i = 0; i < n; i++)
			enqueue(random_command());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		operation = OP_NONE;
		light_id = '0;
		light_type = LT_POSITIONAL;
		enabled = 1'b0;
		hierarchy_active = 1'b0;
		casts_shadow_volume = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		light_range = '0;
		slot_index = '0;
		for (int i = 0; i < CAPACITY; i++)
			held_id[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, registers at reset values
		enqueue(mk(OP_READ, 16'h0000, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_NONE, 16'h5A5A, LT_AMBIENT, 1, 1, 1, 0, 0, 0, 0, 8'hFF));
		enqueue(mk(OP_REFRESH, 16'hFFFF, LT_POSITIONAL, 1, 1, 1, 0, 0, 0, 0, 0));
		enqueue(mk(OP_REFRESH, 16'h0000, LT_DIRECTIONAL, 1, 1, 1,
			24'h800000, 24'h7FFFFF, 24'h800000, 0, 0));
		enqueue(mk(OP_REFRESH, 16'h1234, LT_AMBIENT, 1, 1, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_REFRESH, 16'h4321, LT_AMBIENT, 1, 1, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_REFRESH, 16'h4321, LT_AMBIENT, 0, 1, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_REFRESH, 16'h1234, LT_AMBIENT, 1, 0, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_REFRESH, 16'h0101, LT_OTHER, 1, 1, 0,
			24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 0));
		// exactly on the boundary
		enqueue(mk(OP_REFRESH, 16'h0202, LT_OTHER, 1, 1, 0,
			24'h000100, 0, 0, 23'h000100, 0));
		enqueue(mk(OP_REFRESH, 16'hFFFF, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 0));
		// fill the table, last one overflows
		for (int i = 3; i <= 8; i++)
			enqueue(mk(OP_REFRESH, 16'h0A00 + 16'(i), LT_DIRECTIONAL, 1, 1, 0,
				0, 0, 0, 0, 0));
		enqueue(mk(OP_READ, 0, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 8'd7));
		enqueue(mk(OP_READ, 0, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 8'd8));
		enqueue(mk(OP_READ, 0, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 8'hFF));
		enqueue(mk(OP_REFRESH, 16'h0000, LT_DIRECTIONAL, 0, 1, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_READ, 0, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 8'd1));
		enqueue(mk(OP_REFRESH, 16'h0202, LT_POSITIONAL, 1, 1, 1,
			24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF, 0));
		enqueue(mk(OP_RESET, 0, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 0));
		enqueue(mk(OP_READ, 0, LT_POSITIONAL, 1, 1, 0, 0, 0, 0, 0, 8'd0));
		drain();

		configure(0, 0, 0, 24'h1000, 1'b0);
		idle_pct = 0;
		random_phase(200);

		configure(8388607, -8388608, 24'h123456, 8388607, 1'b1);
		idle_pct = 47;
		random_phase(200);

		configure(-8388608, 8388607, -1, 0, 1'b1);
		idle_pct = 20;
		random_phase(200);

		configure(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
			longint'($signed(24'($urandom))), $urandom_range(16'h3000), 1'($urandom_range(1)));
		idle_pct = 0;
		random_phase(115);
		idle_pct = 47;
		random_phase(115);

		mismatches += selection_q.size();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
